// ===== rtl/dvrm_pkg.sv =====
package dvrm_pkg;

	// Saturation limit of a route cost.
	localparam logic [14:0] COST_MAX = 15'h7FFF;

	// Outcome codes of one merge.
	typedef enum logic [1:0] {
		ST_IMPROVED = 2'd0,
		ST_INSERTED = 2'd1,
		ST_KEPT     = 2'd2,
		ST_FULL     = 2'd3
	} route_status_t;

	// One advertised route, as carried by an input beat.
	typedef struct packed {
		logic [31:0]        from_addr;
		logic [31:0]        recv_iface_addr;
		logic [31:0]        dst_addr;
		logic signed [15:0] adv_cost;
	} route_adv_t;

	// One merge outcome, as carried by an output beat.
	typedef struct packed {
		route_status_t status;
		logic [5:0]    entry_index;
		logic [14:0]   entry_cost;
	} route_result_t;

	// One routing table slot.
	typedef struct packed {
		logic [31:0] dst;
		logic [31:0] next_hop;
		logic [31:0] iface;
		logic [14:0] cost;
	} route_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic resolve;
		logic commit;
	} dvrm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic exhausted;
	} dvrm_stat_t;

	// Cost offered by an advertisement: zero for a negative cost, one for the
	// neighbor itself, otherwise one more than advertised with saturation.
	function automatic logic [14:0] candidate_cost(input logic [31:0] from_addr,
		input logic [31:0] dst_addr, input logic [15:0] adv_cost);
		logic [14:0] c;
		c = adv_cost[14:0];
		if (adv_cost[15]) begin
			return 15'd0;
		end else if (from_addr == dst_addr) begin
			return 15'd1;
		end else if (c == COST_MAX) begin
			return COST_MAX;
		end else begin
			return c + 15'd1;
		end
	endfunction

endpackage

// ===== rtl/dvrm_ctrl.sv =====
module dvrm_ctrl
	import dvrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	output dvrm_cmd_t  cmd,
	input  dvrm_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   done_q;

	// Commands follow the state and the search status.
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.scan    = (state_q == S_SCAN);
		cmd.resolve = (state_q == S_SCAN) && (stat.hit || stat.exhausted);
		cmd.commit  = (state_q == S_COMMIT);
	end

	// State register and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_COMMIT);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.hit || stat.exhausted) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== rtl/dvrm_datapath.sv =====
module dvrm_datapath
	import dvrm_pkg::*;
#(
	parameter int MAX_ROUTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  route_adv_t    item,
	input  dvrm_cmd_t     cmd,
	output dvrm_stat_t    stat,
	output route_result_t result
);

	localparam int IDX_W = $clog2(MAX_ROUTES);
	localparam int CNT_W = $clog2(MAX_ROUTES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ROUTES);

	route_entry_t   mem [MAX_ROUTES];

	route_adv_t     item_q;
	logic [14:0]    cand_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic           rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	route_entry_t   rd_s1;
	logic           hit_q;
	logic [IDX_W-1:0] slot_q;
	logic [14:0]    old_cost_q;
	route_result_t  result_q;

	logic           rd_en;
	logic           full;
	logic           improve;
	logic           insert;
	logic           wr_en;
	logic [IDX_W-1:0] wr_idx;
	route_entry_t   wr_entry;
	logic [IDX_W-1:0] res_idx;
	logic [IDX_W+5:0] res_idx_ext;
	route_result_t  res_next;

	// Slots fill in order, so a slot is valid exactly when it lies below the count.
	assign rd_en = cmd.scan && (addr_q < count_q);

	// Search status: a valid read that matches, or every filled slot examined.
	assign stat.hit       = rd_vld_s1 && (rd_s1.dst == item_q.dst_addr);
	assign stat.exhausted = !rd_vld_s1 && (addr_q == count_q);

	// Merge decision for the commit cycle.
	assign full    = (count_q == CNT_FULL);
	assign improve = hit_q && (cand_q < old_cost_q);
	assign insert  = !hit_q && !full;
	assign wr_en   = cmd.commit && (improve || insert);
	assign wr_idx  = hit_q ? slot_q : count_q[IDX_W-1:0];

	always_comb begin
		wr_entry.dst      = item_q.dst_addr;
		wr_entry.next_hop = item_q.from_addr;
		wr_entry.iface    = item_q.recv_iface_addr;
		wr_entry.cost     = cand_q;
	end

	// Result fields; a full table reports slot zero and cost zero.
	always_comb begin
		res_idx = '0;
		res_next.entry_cost = 15'd0;
		if (hit_q) begin
			res_idx = slot_q;
			if (improve) begin
				res_next.status     = ST_IMPROVED;
				res_next.entry_cost = cand_q;
			end else begin
				res_next.status     = ST_KEPT;
				res_next.entry_cost = old_cost_q;
			end
		end else if (insert) begin
			res_idx             = count_q[IDX_W-1:0];
			res_next.status     = ST_INSERTED;
			res_next.entry_cost = cand_q;
		end else begin
			res_next.status = ST_FULL;
		end
		res_idx_ext          = {6'd0, res_idx};
		res_next.entry_index = res_idx_ext[5:0];
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1     <= mem[addr_q[IDX_W-1:0]];
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		end
	end

	// Search control and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q    <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					addr_q <= addr_q + CNT_W'(1);
				end
			end
			if (cmd.commit && insert) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Item, candidate cost, search outcome and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			cand_q <= candidate_cost(item.from_addr, item.dst_addr, item.adv_cost);
		end
		if (cmd.resolve) begin
			hit_q      <= stat.hit;
			slot_q     <= rd_idx_s1;
			old_cost_q <= rd_s1.cost;
		end
		if (cmd.commit) begin
			result_q <= res_next;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/distance_vector_route_merge_core.sv =====
// Sequence: start loads the advertisement, the scan reads filled slots from slot zero up
// until the destination matches or none is left, then the commit step and done follow.
// Throughput: one advertisement at a time; the table memory's single read port
// examines one slot per cycle. A new start is taken in the cycle that done is shown.
// Reset: arst_n clears the controller, the fill count and the search state; the table
// memory is not cleared, only slots below the fill count are read. done cannot stall.
module distance_vector_route_merge_core
	import dvrm_pkg::*;
#(
	parameter int MAX_ROUTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  route_adv_t    item,
	output logic          done,
	output route_result_t result
);

	dvrm_cmd_t  cmd;
	dvrm_stat_t stat;

	// Sequencer.
	dvrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Table, search and merge datapath.
	dvrm_datapath #(
		.MAX_ROUTES (MAX_ROUTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

`ifndef SYNTH
	// A result beat only appears once the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// An accepted beat makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not start work");

	// Each result lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	// A full table reports slot zero and cost zero.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL)) |->
		((result.entry_index == 6'd0) && (result.entry_cost == 15'd0)))
		else $error("full-table result carries nonzero fields");
`endif

endmodule

// ===== tb/sv/tb_distance_vector_route_merge_core.sv =====
`timescale 1ns / 1ps

module tb_distance_vector_route_merge_core;
	import dvrm_pkg::*;

	localparam int TABLE_SLOTS = 64;
	localparam int POOL_SIZE   = 72;
	localparam int RANDOM_ADVS = 1850;
	localparam int IDLE_LIMIT  = 1000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	route_adv_t    item = '0;
	logic          done;
	route_result_t result;

	// Shadow routing table kept by the testbench.
	logic [31:0] shadow_dst [TABLE_SLOTS];
	logic [31:0] shadow_hop [TABLE_SLOTS];
	logic [31:0] shadow_iface [TABLE_SLOTS];
	logic [14:0] shadow_cost [TABLE_SLOTS];
	int          shadow_fill = 0;

	route_adv_t    advert_q [$];
	route_result_t outcome_q [$];
	logic [31:0]   dst_pool [POOL_SIZE];

	int mismatch_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;

	distance_vector_route_merge_core #(
		.MAX_ROUTES(TABLE_SLOTS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic route_adv_t make_advert(input logic [31:0] from_addr,
		input logic [31:0] iface_addr, input logic [31:0] dst_addr, input logic [15:0] cost);
		route_adv_t a;
		a.from_addr       = from_addr;
		a.recv_iface_addr = iface_addr;
		a.dst_addr        = dst_addr;
		a.adv_cost        = cost;
		return a;
	endfunction

	// Appends one advertisement to the pending queue.
	task automatic queue_advert(input logic [31:0] from_addr, input logic [31:0] iface_addr,
		input logic [31:0] dst_addr, input logic [15:0] cost);
		advert_q = {advert_q, make_advert(from_addr, iface_addr, dst_addr, cost)};
	endtask

	// Merges one advertisement into the shadow table and returns the outcome the
	// block must report for it.
	function automatic route_result_t merge_advert(input route_adv_t a);
		route_result_t r;
		logic [14:0]   offered;
		int            slot;
		slot = -1;
		// Offered cost: negative means zero, the neighbor itself costs one,
		// otherwise one hop more with saturation.
		if (a.adv_cost[15]) begin
			offered = 15'd0;
		end else if (a.from_addr == a.dst_addr) begin
			offered = 15'd1;
		end else if (a.adv_cost[14:0] == 15'h7FFF) begin
			offered = 15'h7FFF;
		end else begin
			offered = a.adv_cost[14:0] + 15'd1;
		end
		// The lowest filled slot holding the destination wins.
		for (int i = 0; i < shadow_fill; i++) begin
			if (slot < 0 && shadow_dst[i] == a.dst_addr) begin
				slot = i;
			end
		end
		if (slot >= 0) begin
			if (offered < shadow_cost[slot]) begin
				shadow_cost[slot]  = offered;
				shadow_hop[slot]   = a.from_addr;
				shadow_iface[slot] = a.recv_iface_addr;
				r.status = ST_IMPROVED;
			end else begin
				r.status = ST_KEPT;
			end
			r.entry_index = slot[5:0];
			r.entry_cost  = shadow_cost[slot];
		end else if (shadow_fill < TABLE_SLOTS) begin
			shadow_dst[shadow_fill]   = a.dst_addr;
			shadow_hop[shadow_fill]   = a.from_addr;
			shadow_iface[shadow_fill] = a.recv_iface_addr;
			shadow_cost[shadow_fill]  = offered;
			r.status      = ST_INSERTED;
			r.entry_index = shadow_fill[5:0];
			r.entry_cost  = offered;
			shadow_fill++;
		end else begin
			r.status      = ST_FULL;
			r.entry_index = 6'd0;
			r.entry_cost  = 15'd0;
		end
		return r;
	endfunction

	// Driver: offers queued advertisements in bursts separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			if (start && !busy) begin
				outcome_q = {outcome_q, merge_advert(item)};
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start    <= 1'b0;
				end else if (advert_q.size() > 0) begin
					start <= 1'b1;
					item  <= advert_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 90);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result beat is checked against the oldest outcome owed.
	always @(posedge clk) begin : result_check
		route_result_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", result));
			end else begin
				want = outcome_q.pop_front();
				if (result.status !== want.status || result.entry_index !== want.entry_index
					|| result.entry_cost !== want.entry_cost) begin
					report_mismatch($sformatf("got %p, want %p", result, want));
				end
			end
		end
	end

	// Watchdog: too long without an accepted beat on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int          lim;
		int          pick;
		bit          dup;
		logic [31:0] dst;
		logic [31:0] from;
		logic [15:0] cost;

		// Distinct random destinations, none equal to the all-zero or all-one address.
		for (int i = 0; i < POOL_SIZE; i++) begin
			do begin
				dst_pool[i] = $urandom;
				dup = (dst_pool[i] == 32'h0) || (dst_pool[i] == 32'hFFFF_FFFF);
				for (int j = 0; j < i; j++) begin
					if (dst_pool[j] == dst_pool[i]) begin
						dup = 1'b1;
					end
				end
			end while (dup);
		end

		// Directed part: address extremes, negative and saturating costs, the neighbor
		// as its own destination, equal-cost ties and strict improvements.
		queue_advert(32'hFFFF_FFFF, 32'h0, 32'h0, 16'd0);
		queue_advert(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF);
		queue_advert(32'h1234_5678, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h7FFE);
		queue_advert(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 16'd100);
		queue_advert(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 16'd100);
		queue_advert(32'h0102_0304, 32'hC0A8_0101, 32'hFFFF_FFFF, 16'hFFFF);
		queue_advert(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'd5);
		queue_advert(32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
		queue_advert(dst_pool[0], 32'h8000_0001, dst_pool[0], 16'h7FFF);
		queue_advert(32'h7FFF_FFFF, 32'h0000_FFFF, dst_pool[1], 16'hFFFF);
		queue_advert(32'h8000_0000, 32'hFFFF_0000, dst_pool[2], 16'h7FFF);
		queue_advert(32'h8000_0000, 32'hFFFF_0000, dst_pool[2], 16'h7FFF);
		queue_advert(32'hAAAA_AAAA, 32'h5555_5555, dst_pool[2], 16'h5555);
		queue_advert(32'h5555_5555, 32'hAAAA_AAAA, dst_pool[2], 16'h2AAA);
		queue_advert(32'hDEAD_0000, 32'h0000_BEEF, dst_pool[2], 16'd0);
		queue_advert(32'h0, 32'h0, dst_pool[3], 16'd1);
		queue_advert(32'hFFFF_FFFF, 32'hFFFF_FFFF, dst_pool[3], 16'd1);

		// Random part: the destination pool widens slowly so the table fills over the
		// run, deep searches dominate, and the full table is reached well before the end.
		for (int n = 0; n < RANDOM_ADVS; n++) begin
			lim = 4 + n / 16;
			if (lim > POOL_SIZE - 1) begin
				lim = POOL_SIZE - 1;
			end
			dst = ($urandom_range(0, 99) < 3) ? $urandom : dst_pool[$urandom_range(0, lim)];
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				cost = 16'hFFFF;
			end else if (pick < 13) begin
				cost = 16'h7FFF;
			end else if (pick < 18) begin
				cost = 16'h7FFE;
			end else if (pick < 48) begin
				cost = 16'($urandom_range(0, 32767));
			end else begin
				cost = 16'($urandom_range(0, 60));
			end
			from = ($urandom_range(0, 99) < 8) ? dst : $urandom;
			queue_advert(from, $urandom, dst, cost);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything offered and every outcome seen, then a settling pause.
		@(negedge clk);
		while (advert_q.size() != 0 || start || outcome_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (80) @(negedge clk);
		if (outcome_q.size() != 0) begin
			report_mismatch($sformatf("%0d outcomes never reported", outcome_q.size()));
		end
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dvrm_pkg.sv
rtl/dvrm_ctrl.sv
rtl/dvrm_datapath.sv
rtl/distance_vector_route_merge_core.sv
tb/sv/tb_distance_vector_route_merge_core.sv
